### hw/rtl/range_sum_point_update_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the range sum / point update block
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef RANGE_SUM_POINT_UPDATE_ASSERT_SVH
`define RANGE_SUM_POINT_UPDATE_ASSERT_SVH

// same-cycle implication
`define RSPU_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RSPU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// implication that also holds while reset is applied
`define RSPU_ASSERT_NEXT_RST(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/rspu_pkg.sv
// ----------------------------------------------------------------------------
// rspu_pkg
// Sizes and shared types of the segment tree range sum block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rspu_pkg;

   // tree geometry: leaf i lives at node LEAF_COUNT + i, node 1 is the root
   localparam int LEAF_BITS   = 10;
   localparam int LEAF_COUNT  = 1 << LEAF_BITS;
   localparam int NODE_BITS   = LEAF_BITS + 1;
   localparam int NODE_COUNT  = 1 << NODE_BITS;
   // walk pointers may reach NODE_COUNT itself
   localparam int WALK_BITS   = LEAF_BITS + 2;
   localparam int VALUE_BITS  = 16;
   localparam int TOTAL_BITS  = 26;
   localparam int LENGTH_BITS = 11;

   // operation codes
   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   // node store write port
   typedef struct packed {
      logic                  en;
      logic [NODE_BITS-1:0]  addr;
      logic [TOTAL_BITS-1:0] data;
   } rspu_wr_type;

   // node store read addresses, two ports
   typedef struct packed {
      logic [NODE_BITS-1:0] addr_a;
      logic [NODE_BITS-1:0] addr_b;
   } rspu_rd_type;

endpackage

### hw/rtl/rspu_node_ram.sv
// ----------------------------------------------------------------------------
// rspu_node_ram
// Node sum store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rspu_node_ram (
   input  logic                           clock,
   input  rspu_pkg::rspu_wr_type          wr,
   input  rspu_pkg::rspu_rd_type          rd,
   output logic [rspu_pkg::TOTAL_BITS-1:0] rd_data_a_ff,
   output logic [rspu_pkg::TOTAL_BITS-1:0] rd_data_b_ff
);
   import rspu_pkg::*;

   logic [TOTAL_BITS-1:0] mem [NODE_COUNT];

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // read ports, registered read data
   always_ff @(posedge clock) begin
      rd_data_a_ff <= mem[rd.addr_a];
      rd_data_b_ff <= mem[rd.addr_b];
   end

endmodule

### hw/rtl/range_sum_point_update.sv
// ----------------------------------------------------------------------------
// range_sum_point_update
// Segment tree of signed partial sums with point update and range sum query.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. operation selects an
//   update (element_index <- element_value) or a query (sum of range_low ..
//   range_high inclusive).
//   A query returns one beat on rsp_valid for one cycle. A valid update
//   returns nothing; a bad index or an inverted range returns one beat with
//   bad_request set and a zero total, the cycle after acceptance.
//   Update: busy after acceptance until the walk writes the root, one tree
//   level per cycle (read sibling, write parent), bound by the node store's
//   single write port. Query: the two walk ends read both node store ports
//   each cycle and climb a level at a time; a last step folds in the final
//   reads, so the result shows and busy drops with it.
//   csr_write_data sets the array length (saturated to 1024); write it only
//   while idle.
//   Reset: the node store is swept to zero, one entry a cycle, with busy
//   high. The receiver cannot stall: each beat stands one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module range_sum_point_update (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_operation,
   input  logic [rspu_pkg::LEAF_BITS-1:0]        req_element_index,
   input  logic signed [rspu_pkg::VALUE_BITS-1:0] req_element_value,
   input  logic [rspu_pkg::LEAF_BITS-1:0]        req_range_low,
   input  logic [rspu_pkg::LEAF_BITS-1:0]        req_range_high,
   // response channel
   output logic                                  rsp_valid,
   output logic signed [rspu_pkg::TOTAL_BITS-1:0] rsp_range_total,
   output logic                                  rsp_bad_request,
   // configuration
   input  logic                                  csr_write_enable,
   input  logic [rspu_pkg::LENGTH_BITS-1:0]      csr_write_data
);
   import rspu_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPD,
      ST_QRY
   } state_type;

   state_type             state_ff, state_in;
   logic [WALK_BITS-1:0]  node_ff, node_in;     // update path node / query left end
   logic [WALK_BITS-1:0]  right_ff, right_in;   // query right end (exclusive)
   logic [TOTAL_BITS-1:0] cur_ff, cur_in;       // update running node sum
   logic [TOTAL_BITS-1:0] acc_ff, acc_in;       // query accumulator
   logic                  pend_l_ff, pend_l_in;
   logic                  pend_r_ff, pend_r_in;
   logic [NODE_BITS-1:0]  clr_addr_ff, clr_addr_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_BITS-1:0] rsp_total_ff, rsp_total_in;
   logic                  rsp_bad_ff, rsp_bad_in;

   rspu_wr_type           wr;
   rspu_rd_type           rd;
   logic [TOTAL_BITS-1:0] rd_data_a, rd_data_b;

   logic [LENGTH_BITS-1:0] eff_len;
   logic [NODE_BITS-1:0]   leaf_addr;
   logic [NODE_BITS-1:0]   parent_addr;
   logic [TOTAL_BITS-1:0]  leaf_value;
   logic [TOTAL_BITS-1:0]  up_sum;
   logic [TOTAL_BITS-1:0]  q_sum;
   logic [WALK_BITS-1:0]   right_dec;
   logic                   upd_bad;
   logic                   qry_bad;

   rspu_node_ram u_ram (
      .clock        (clock),
      .wr           (wr),
      .rd           (rd),
      .rd_data_a_ff (rd_data_a),
      .rd_data_b_ff (rd_data_b)
   );

   // length in use, saturated to the leaf count
   assign eff_len = (len_ff > LENGTH_BITS'(LEAF_COUNT)) ? LENGTH_BITS'(LEAF_COUNT) : len_ff;

   // request checks
   assign upd_bad = ({1'b0, req_element_index} >= eff_len);
   assign qry_bad = ({1'b0, req_range_high} >= eff_len) || (req_range_low > req_range_high);

   // datapath terms
   assign leaf_addr   = {1'b1, req_element_index};
   assign leaf_value  = {{(TOTAL_BITS - VALUE_BITS){req_element_value[VALUE_BITS-1]}},
                         req_element_value};
   assign parent_addr = {1'b0, node_ff[NODE_BITS-1:1]};
   assign up_sum      = cur_ff + rd_data_a;
   assign q_sum       = acc_ff + (pend_l_ff ? rd_data_a : '0) + (pend_r_ff ? rd_data_b : '0);
   assign right_dec   = right_ff - WALK_BITS'(1);

   // next state and store access
   always_comb begin
      state_in     = state_ff;
      node_in      = node_ff;
      right_in     = right_ff;
      cur_in       = cur_ff;
      acc_in       = acc_ff;
      pend_l_in    = 1'b0;
      pend_r_in    = 1'b0;
      clr_addr_in  = clr_addr_ff;
      len_in       = csr_write_enable ? csr_write_data : len_ff;
      rsp_valid_in = 1'b0;
      rsp_total_in = rsp_total_ff;
      rsp_bad_in   = rsp_bad_ff;
      wr           = '0;
      rd.addr_a    = node_ff[NODE_BITS-1:0];
      rd.addr_b    = right_dec[NODE_BITS-1:0];

      case (state_ff)
         ST_CLEAR: begin
            // zero sweep over the node store
            wr.en       = 1'b1;
            wr.addr     = clr_addr_ff;
            wr.data     = '0;
            clr_addr_in = clr_addr_ff + NODE_BITS'(1);
            if (clr_addr_ff == {NODE_BITS{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (req_operation == OP_UPDATE) begin
                  if (upd_bad) begin
                     rsp_valid_in = 1'b1;
                     rsp_total_in = '0;
                     rsp_bad_in   = 1'b1;
                  end else begin
                     // write the leaf, fetch its sibling
                     wr.en     = 1'b1;
                     wr.addr   = leaf_addr;
                     wr.data   = leaf_value;
                     rd.addr_a = leaf_addr ^ NODE_BITS'(1);
                     cur_in    = leaf_value;
                     node_in   = {1'b0, leaf_addr};
                     state_in  = ST_UPD;
                  end
               end else begin
                  if (qry_bad) begin
                     rsp_valid_in = 1'b1;
                     rsp_total_in = '0;
                     rsp_bad_in   = 1'b1;
                  end else begin
                     node_in  = {2'b01, req_range_low};
                     right_in = {2'b01, req_range_high} + WALK_BITS'(1);
                     acc_in   = '0;
                     state_in = ST_QRY;
                  end
               end
            end
         end
         ST_UPD: begin
            // parent <- this node + sibling, fetch the parent's sibling
            wr.en     = 1'b1;
            wr.addr   = parent_addr;
            wr.data   = up_sum;
            rd.addr_a = parent_addr ^ NODE_BITS'(1);
            cur_in    = up_sum;
            node_in   = {1'b0, parent_addr};
            if (parent_addr == NODE_BITS'(1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_QRY: begin
            // fold in last cycle's reads, then step both ends up a level
            acc_in = q_sum;
            if (node_ff < right_ff) begin
               pend_l_in = node_ff[0];
               pend_r_in = right_ff[0];
               node_in   = (node_ff + WALK_BITS'(node_ff[0])) >> 1;
               right_in  = right_ff >> 1;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_total_in = q_sum;
               rsp_bad_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         len_ff       <= LENGTH_BITS'(LEAF_COUNT);
         pend_l_ff    <= 1'b0;
         pend_r_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         len_ff       <= len_in;
         pend_l_ff    <= pend_l_in;
         pend_r_ff    <= pend_r_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      node_ff      <= node_in;
      right_ff     <= right_in;
      cur_ff       <= cur_in;
      acc_ff       <= acc_in;
      rsp_total_ff <= rsp_total_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_range_total = rsp_total_ff;
   assign rsp_bad_request = rsp_bad_ff;

endmodule

### hw/rtl/rspu_checker.sv
// ----------------------------------------------------------------------------
// rspu_checker
// Port-level checks on the range sum block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "range_sum_point_update_assert.svh"

module rspu_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  start,
   input logic                                  busy,
   input logic                                  req_operation,
   input logic [rspu_pkg::LEAF_BITS-1:0]        req_range_low,
   input logic [rspu_pkg::LEAF_BITS-1:0]        req_range_high,
   input logic                                  rsp_valid,
   input logic signed [rspu_pkg::TOTAL_BITS-1:0] rsp_range_total,
   input logic                                  rsp_bad_request
);
   import rspu_pkg::*;

   logic take_inverted;

   // query accepted with its range upside down
   assign take_inverted = start && !busy && (req_operation == OP_QUERY) &&
                          (req_range_low > req_range_high);

   // reset starts the clearing sweep
   `RSPU_ASSERT_NEXT_RST(a_reset_busy, clock, reset, busy, "busy low after reset")

   // an error beat carries a zero total
   `RSPU_ASSERT_SAME(a_bad_zero, clock, reset, rsp_valid && rsp_bad_request, rsp_range_total == '0, "error beat with nonzero total")

   // an inverted range is flagged on the next cycle
   `RSPU_ASSERT_NEXT(a_inverted_flag, clock, reset, take_inverted, rsp_valid && rsp_bad_request, "inverted range not flagged")

   // a beat follows either work in progress or an acceptance
   `RSPU_ASSERT_SAME(a_beat_cause, clock, reset, rsp_valid && !$past(reset), $past(busy) || $past(start), "response beat without a request")

endmodule

bind range_sum_point_update rspu_checker u_rspu_checker (.*);
